/* sv/fse_pkg.sv */
// ----------------------------------------------------------------------------
// fse_pkg: shared definitions for the Forth stack execution unit
// Word codes, status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package fse_pkg;

    localparam int DEF_DATA_DEPTH   = 64;
    localparam int DEF_RETURN_DEPTH = 64;
    localparam int CELL_W           = 32;
    localparam int CELL_BYTES       = 4;

    typedef enum logic [5:0] {
        OP_LIT      = 6'd0,  OP_DROP   = 6'd1,  OP_SWAP   = 6'd2,  OP_DUP    = 6'd3,
        OP_PICK     = 6'd4,  OP_STICK  = 6'd5,  OP_NTUCK  = 6'd6,  OP_OVER   = 6'd7,
        OP_ROT      = 6'd8,  OP_MROT   = 6'd9,  OP_DROP2  = 6'd10, OP_DUP2   = 6'd11,
        OP_SWAP2    = 6'd12, OP_QDUP   = 6'd13, OP_TO_R   = 6'd14, OP_R_FROM = 6'd15,
        OP_RDROP    = 6'd16, OP_INC    = 6'd17, OP_DEC    = 6'd18, OP_CELL_ADD = 6'd19,
        OP_CELL_SUB = 6'd20, OP_ADD    = 6'd21, OP_SUB    = 6'd22, OP_MUL    = 6'd23,
        OP_DIV      = 6'd24, OP_MOD    = 6'd25, OP_NEGATE = 6'd26, OP_DIVMOD = 6'd27,
        OP_EQ       = 6'd28, OP_NE     = 6'd29, OP_LT     = 6'd30, OP_GT     = 6'd31,
        OP_LE       = 6'd32, OP_GE     = 6'd33, OP_ZEQ    = 6'd34, OP_ZNE    = 6'd35,
        OP_ZLT      = 6'd36, OP_ZGT    = 6'd37, OP_ZLE    = 6'd38, OP_ZGE    = 6'd39,
        OP_AND      = 6'd40, OP_OR     = 6'd41, OP_XOR    = 6'd42, OP_INVERT = 6'd43
    } op_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_UNDER  = 3'd1,
        ST_OVER   = 3'd2,
        ST_DIVZ   = 3'd3,
        ST_BADIDX = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_CHECK, S_PICK_RD, S_PICK_WT, S_DIV, S_TUCK, S_TUCK_END,
        S_WRITE, S_COMMIT, S_TOP0, S_TOP1, S_TOP2, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic check;
        logic pick_rd;
        logic pick_cap;
        logic div;
        logic write;
        logic tuck;
        logic tuck_end;
        logic commit;
        logic top0;
        logic top1;
        logic top2;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fetch_done;
        logic err;
        logic is_pick;
        logic is_tuck;
        logic is_div;
        logic div_done;
        logic write_done;
        logic tuck_done;
    } stat_t;

endpackage

/* sv/fse_ram.sv */
// ----------------------------------------------------------------------------
// fse_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/fse_datapath.sv */
// ----------------------------------------------------------------------------
// fse_datapath: stacks, operand registers, ALU and divider
// Carries out the phases commanded by the controller.
// ----------------------------------------------------------------------------
module fse_datapath import fse_pkg::*; #(
    parameter int DATA_DEPTH   = DEF_DATA_DEPTH,
    parameter int RETURN_DEPTH = DEF_RETURN_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [5:0]        operation,
    input  logic [CELL_W-1:0] literal_value,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output logic [CELL_W-1:0] top_cell,
    output logic [CELL_W-1:0] second_cell,
    output logic [6:0]        data_depth,
    output logic [6:0]        return_depth,
    output logic [2:0]        status
);

    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int DXW = DCW + 1;
    localparam int RAW = $clog2(RETURN_DEPTH);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);
    localparam int RXW = RCW + 1;

    logic [5:0]        op_reg;
    logic [CELL_W-1:0] lit_reg;
    logic [CELL_W-1:0] x_reg [4];
    logic [CELL_W-1:0] rtop_reg;
    logic [CELL_W-1:0] res_reg [4];
    logic [CELL_W-1:0] res_c [4];
    logic [DCW-1:0]    dcnt_reg;
    logic [RCW-1:0]    rcnt_reg;
    logic [2:0]        fk_reg;
    logic [2:0]        wk_reg;
    logic [DAW-1:0]    tc_reg;
    logic [5:0]        dc_reg;
    logic [CELL_W-1:0] rem_reg;
    logic [CELL_W-1:0] quo_reg;
    logic [CELL_W-1:0] dvs_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    status_t           stat_reg;
    status_t           chk_c;
    logic              tao_reg;
    logic [CELL_W-1:0] top_reg;
    logic [CELL_W-1:0] sec_reg;

    logic [2:0]        need;
    logic [2:0]        prod;
    logic              rneed;
    logic              rprod;
    logic [2:0]        kk;
    logic [DAW-1:0]    xi;
    logic [CELL_W-1:0] tv;
    logic [CELL_W-1:0] qv;
    logic [CELL_W-1:0] rv;
    logic [CELL_W:0]   rem_sh;
    logic [CELL_W:0]   diff;
    logic              is_divop;

    logic              d_we;
    logic [DAW-1:0]    d_waddr;
    logic [CELL_W-1:0] d_wdata;
    logic [DAW-1:0]    d_raddr;
    logic [CELL_W-1:0] d_rdata;
    logic              r_we;
    logic [CELL_W-1:0] r_rdata;

    fse_ram #(.WIDTH(CELL_W), .DEPTH(DATA_DEPTH)) u_data_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    fse_ram #(.WIDTH(CELL_W), .DEPTH(RETURN_DEPTH)) u_ret_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (RAW'(rcnt_reg)),
        .wdata (x_reg[0]),
        .raddr (RAW'(rcnt_reg) - RAW'(1)),
        .rdata (r_rdata)
    );

    assign xi       = x_reg[0][DAW-1:0];
    assign kk       = fk_reg - 3'd1;
    assign tv       = tao_reg ? '1 : CELL_W'(1);
    assign is_divop = (op_reg == OP_DIV) || (op_reg == OP_MOD) || (op_reg == OP_DIVMOD);

    // stack effect of each word
    always_comb
    begin
        need  = 3'd0;
        prod  = 3'd0;
        rneed = 1'b0;
        rprod = 1'b0;
        unique case (op_reg) inside
            OP_LIT:                   prod = 3'd1;
            OP_DROP, OP_NTUCK:        need = 3'd1;
            OP_SWAP, OP_DIVMOD:       begin need = 3'd2; prod = 3'd2; end
            OP_DUP:                   begin need = 3'd1; prod = 3'd2; end
            OP_PICK:                  begin need = 3'd1; prod = 3'd1; end
            OP_STICK, OP_DROP2:       need = 3'd2;
            OP_OVER:                  begin need = 3'd2; prod = 3'd3; end
            OP_ROT, OP_MROT:          begin need = 3'd3; prod = 3'd3; end
            OP_DUP2:                  begin need = 3'd2; prod = 3'd4; end
            OP_SWAP2:                 begin need = 3'd4; prod = 3'd4; end
            OP_QDUP:
            begin
                need = 3'd1;
                prod = (x_reg[0] != '0) ? 3'd2 : 3'd1;
            end
            OP_TO_R:                  begin need = 3'd1; rprod = 1'b1; end
            OP_R_FROM:                begin prod = 3'd1; rneed = 1'b1; end
            OP_RDROP:                 rneed = 1'b1;
            OP_INC, OP_DEC, OP_CELL_ADD, OP_CELL_SUB, OP_NEGATE, OP_ZEQ, OP_ZNE,
            OP_ZLT, OP_ZGT, OP_ZLE, OP_ZGE, OP_INVERT:
                                      begin need = 3'd1; prod = 3'd1; end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NE, OP_LT, OP_GT,
            OP_LE, OP_GE, OP_AND, OP_OR, OP_XOR:
                                      begin need = 3'd2; prod = 3'd1; end
            default:                  ;
        endcase
    end

    // checks in priority order; unknown words pass untouched
    always_comb
    begin
        chk_c = ST_OK;
        if (op_reg <= 6'(OP_INVERT))
        begin
            if ((dcnt_reg < DCW'(need)) || (rcnt_reg < RCW'(rneed)))
                chk_c = ST_UNDER;
            else if ((DXW'(dcnt_reg) + DXW'(prod)) > (DXW'(DATA_DEPTH) + DXW'(need)) ||
                     (RXW'(rcnt_reg) + RXW'(rprod)) > (RXW'(RETURN_DEPTH) + RXW'(rneed)))
                chk_c = ST_OVER;
            else if (is_divop && (x_reg[0] == '0))
                chk_c = ST_DIVZ;
            else if (((op_reg == OP_PICK) || (op_reg == OP_NTUCK)) &&
                     (x_reg[0] >= (CELL_W'(dcnt_reg) - CELL_W'(1))))
                chk_c = ST_BADIDX;
            else if ((op_reg == OP_STICK) && (x_reg[0] >= (CELL_W'(dcnt_reg) - CELL_W'(2))))
                chk_c = ST_BADIDX;
        end
    end

    // combinational results
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            res_c[i] = '0;
        end
        case (op_reg)
            OP_LIT:      res_c[0] = lit_reg;
            OP_SWAP:     begin res_c[0] = x_reg[0]; res_c[1] = x_reg[1]; end
            OP_DUP, OP_QDUP:
                         begin res_c[0] = x_reg[0]; res_c[1] = x_reg[0]; end
            OP_OVER:     begin res_c[0] = x_reg[1]; res_c[1] = x_reg[0]; res_c[2] = x_reg[1]; end
            OP_ROT:      begin res_c[0] = x_reg[1]; res_c[1] = x_reg[0]; res_c[2] = x_reg[2]; end
            OP_MROT:     begin res_c[0] = x_reg[0]; res_c[1] = x_reg[2]; res_c[2] = x_reg[1]; end
            OP_DUP2:
            begin
                res_c[0] = x_reg[1]; res_c[1] = x_reg[0];
                res_c[2] = x_reg[1]; res_c[3] = x_reg[0];
            end
            OP_SWAP2:
            begin
                res_c[0] = x_reg[1]; res_c[1] = x_reg[0];
                res_c[2] = x_reg[3]; res_c[3] = x_reg[2];
            end
            OP_R_FROM:   res_c[0] = rtop_reg;
            OP_INC:      res_c[0] = x_reg[0] + CELL_W'(1);
            OP_DEC:      res_c[0] = x_reg[0] - CELL_W'(1);
            OP_CELL_ADD: res_c[0] = x_reg[0] + CELL_W'(CELL_BYTES);
            OP_CELL_SUB: res_c[0] = x_reg[0] - CELL_W'(CELL_BYTES);
            OP_ADD:      res_c[0] = x_reg[1] + x_reg[0];
            OP_SUB:      res_c[0] = x_reg[1] - x_reg[0];
            OP_MUL:      res_c[0] = x_reg[1] * x_reg[0];
            OP_NEGATE:   res_c[0] = '0 - x_reg[0];
            OP_EQ:       res_c[0] = (x_reg[1] == x_reg[0]) ? tv : '0;
            OP_NE:       res_c[0] = (x_reg[1] != x_reg[0]) ? tv : '0;
            OP_LT:       res_c[0] = ($signed(x_reg[1]) < $signed(x_reg[0])) ? tv : '0;
            OP_GT:       res_c[0] = ($signed(x_reg[0]) < $signed(x_reg[1])) ? tv : '0;
            OP_LE:       res_c[0] = ($signed(x_reg[1]) <= $signed(x_reg[0])) ? tv : '0;
            OP_GE:       res_c[0] = ($signed(x_reg[1]) >= $signed(x_reg[0])) ? tv : '0;
            OP_ZEQ:      res_c[0] = (x_reg[0] == '0) ? tv : '0;
            OP_ZNE:      res_c[0] = (x_reg[0] != '0) ? tv : '0;
            OP_ZLT:      res_c[0] = x_reg[0][CELL_W-1] ? tv : '0;
            OP_ZGT:      res_c[0] = ($signed(x_reg[0]) > 0) ? tv : '0;
            OP_ZLE:      res_c[0] = ($signed(x_reg[0]) <= 0) ? tv : '0;
            OP_ZGE:      res_c[0] = (!x_reg[0][CELL_W-1]) ? tv : '0;
            OP_AND:      res_c[0] = x_reg[1] & x_reg[0];
            OP_OR:       res_c[0] = x_reg[1] | x_reg[0];
            OP_XOR:      res_c[0] = x_reg[1] ^ x_reg[0];
            OP_INVERT:   res_c[0] = ~x_reg[0];
            default:     ;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[CELL_W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign qv     = neg_q_reg ? ('0 - quo_reg) : quo_reg;
    assign rv     = neg_r_reg ? ('0 - rem_reg) : rem_reg;

    // data RAM ports
    always_comb
    begin
        d_raddr = DAW'(dcnt_reg) - DAW'(fk_reg) - DAW'(1);
        if (cmd.pick_rd)
            d_raddr = DAW'(dcnt_reg) - DAW'(2) - xi;
        else if (cmd.tuck)
            d_raddr = DAW'(dcnt_reg) - DAW'(3) - tc_reg;
        else if (cmd.top0)
            d_raddr = DAW'(dcnt_reg) - DAW'(1);
        else if (cmd.top1)
            d_raddr = DAW'(dcnt_reg) - DAW'(2);

        d_we    = 1'b0;
        d_waddr = DAW'(dcnt_reg) - DAW'(3) - xi;
        d_wdata = x_reg[1];
        if (cmd.check && (chk_c == ST_OK) && (op_reg == OP_STICK))
        begin
            d_we = 1'b1;
        end
        else if (cmd.write && (wk_reg < prod))
        begin
            d_we    = 1'b1;
            d_waddr = DAW'(dcnt_reg) - DAW'(need) + DAW'(wk_reg);
            d_wdata = res_reg[wk_reg[1:0]];
        end
        else if (cmd.tuck && (tc_reg != '0))
        begin
            d_we    = 1'b1;
            d_waddr = DAW'(dcnt_reg) - DAW'(1) - tc_reg;
            d_wdata = d_rdata;
        end
        else if (cmd.tuck_end)
        begin
            d_we    = 1'b1;
            d_waddr = DAW'(dcnt_reg) - DAW'(2) - xi;
        end
    end

    assign r_we = cmd.check && (chk_c == ST_OK) && (op_reg == OP_TO_R);

    assign stat.fetch_done = (fk_reg == 3'd4);
    assign stat.err        = (chk_c != ST_OK);
    assign stat.is_pick    = (op_reg == OP_PICK);
    assign stat.is_tuck    = (op_reg == OP_NTUCK);
    assign stat.is_div     = is_divop;
    assign stat.div_done   = (dc_reg == '0);
    assign stat.write_done = ({1'b0, wk_reg} + 4'd1) >= {1'b0, prod};
    assign stat.tuck_done  = (tc_reg == xi);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
            rcnt_reg <= '0;
            tao_reg  <= 1'b1;
            fk_reg   <= '0;
            wk_reg   <= '0;
            tc_reg   <= '0;
            dc_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                tao_reg <= cfg_data;
            if (cmd.load)
                fk_reg <= '0;
            else if (cmd.fetch && (fk_reg != 3'd4))
                fk_reg <= fk_reg + 3'd1;
            if (cmd.check)
            begin
                wk_reg <= '0;
                tc_reg <= '0;
                dc_reg <= (chk_c == ST_OK && is_divop) ? 6'd32 : 6'd0;
            end
            if (cmd.write)
                wk_reg <= wk_reg + 3'd1;
            if (cmd.tuck)
                tc_reg <= tc_reg + DAW'(1);
            if (cmd.div && (dc_reg != '0))
                dc_reg <= dc_reg - 6'd1;
            if (cmd.commit && (stat_reg == ST_OK))
            begin
                dcnt_reg <= dcnt_reg - DCW'(need) + DCW'(prod);
                rcnt_reg <= rcnt_reg - RCW'(rneed) + RCW'(rprod);
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            lit_reg <= literal_value;
        end
        if (cmd.fetch && (fk_reg != 3'd0))
        begin
            x_reg[kk[1:0]] <= (DCW'(kk) < dcnt_reg) ? d_rdata : '0;
            if (fk_reg == 3'd1)
                rtop_reg <= (rcnt_reg != '0) ? r_rdata : '0;
        end
        if (cmd.check)
        begin
            stat_reg <= chk_c;
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= res_c[i];
            end
            rem_reg   <= '0;
            quo_reg   <= x_reg[1][CELL_W-1] ? ('0 - x_reg[1]) : x_reg[1];
            dvs_reg   <= x_reg[0][CELL_W-1] ? ('0 - x_reg[0]) : x_reg[0];
            neg_q_reg <= x_reg[1][CELL_W-1] ^ x_reg[0][CELL_W-1];
            neg_r_reg <= x_reg[1][CELL_W-1];
        end
        if (cmd.div)
        begin
            if (dc_reg != '0)
            begin
                if (!diff[CELL_W])
                begin
                    rem_reg <= diff[CELL_W-1:0];
                    quo_reg <= {quo_reg[CELL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[CELL_W-1:0];
                    quo_reg <= {quo_reg[CELL_W-2:0], 1'b0};
                end
            end
            else if (op_reg == OP_DIV)
                res_reg[0] <= qv;
            else
            begin
                res_reg[0] <= rv;
                res_reg[1] <= qv;
            end
        end
        if (cmd.pick_cap)
            res_reg[0] <= d_rdata;
        if (cmd.top1)
            top_reg <= (dcnt_reg != '0) ? d_rdata : '0;
        if (cmd.top2)
            sec_reg <= (dcnt_reg >= DCW'(2)) ? d_rdata : '0;
        if (cmd.out_load)
        begin
            top_cell     <= top_reg;
            second_cell  <= sec_reg;
            data_depth   <= 7'(dcnt_reg);
            return_depth <= 7'(rcnt_reg);
            status       <= stat_reg;
        end
    end

endmodule

/* sv/fse_ctrl.sv */
// ----------------------------------------------------------------------------
// fse_ctrl: sequencer for one word
// Walks fetch, check, execute, commit, top read and result hand-off.
// ----------------------------------------------------------------------------
module fse_ctrl import fse_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    output cmd_t  cmd,
    input  stat_t stat
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (stat.fetch_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.err)
                    state_next = S_TOP0;
                else if (stat.is_pick)
                    state_next = S_PICK_RD;
                else if (stat.is_tuck)
                    state_next = S_TUCK;
                else if (stat.is_div)
                    state_next = S_DIV;
                else
                    state_next = S_WRITE;
            end
            S_PICK_RD:
            begin
                cmd.pick_rd = 1'b1;
                state_next  = S_PICK_WT;
            end
            S_PICK_WT:
            begin
                cmd.pick_cap = 1'b1;
                state_next   = S_WRITE;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (stat.div_done)
                    state_next = S_WRITE;
            end
            S_TUCK:
            begin
                cmd.tuck = 1'b1;
                if (stat.tuck_done)
                    state_next = S_TUCK_END;
            end
            S_TUCK_END:
            begin
                cmd.tuck_end = 1'b1;
                state_next   = S_COMMIT;
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.write_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_TOP0;
            end
            S_TOP0:
            begin
                cmd.top0   = 1'b1;
                state_next = S_TOP1;
            end
            S_TOP1:
            begin
                cmd.top1   = 1'b1;
                state_next = S_TOP2;
            end
            S_TOP2:
            begin
                cmd.top2   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

/* sv/forth_stack_execution_unit.sv */
// ----------------------------------------------------------------------------
// forth_stack_execution_unit: Forth primitive executor
// Flow: fetch, check, execute, commit, top readback, result; results of more
//   than one cell, PICK, n-TUCK and the division words take extra steps, and a
//   word that fails its checks skips execute and commit.
// Throughput: one request at a time, the next taken in the cycle after the result
//   loads; fetch/commit/readback of the stack RAM sets the rate. A finished result
//   waits in an output register meanwhile.
// Reset: both stacks empty, true flag = all ones; stack RAM is not cleared.
// ----------------------------------------------------------------------------
module forth_stack_execution_unit import fse_pkg::*; #(
    parameter int DATA_DEPTH   = DEF_DATA_DEPTH,
    parameter int RETURN_DEPTH = DEF_RETURN_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [5:0]               operation,
    input  logic signed [CELL_W-1:0] literal_value,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [CELL_W-1:0] top_cell,
    output logic signed [CELL_W-1:0] second_cell,
    output logic [6:0]               data_depth,
    output logic [6:0]               return_depth,
    output logic [2:0]               status,
    // true_all_ones register write
    input  logic                     cfg_we,
    input  logic                     cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer: one word per request, phases driven over cmd.
    fse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath: both stack RAMs, top-four operand cache, ALU and divider.
    fse_datapath #(
        .DATA_DEPTH   (DATA_DEPTH),
        .RETURN_DEPTH (RETURN_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .literal_value (literal_value),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .top_cell      (top_cell),
        .second_cell   (second_cell),
        .data_depth    (data_depth),
        .return_depth  (return_depth),
        .status        (status)
    );

endmodule
